[rtl/zba_pkg.sv]
// zone bitmap allocator package: map geometry, status and request codes,
// request and response payload types. no dependencies.
package zba_pkg;

   localparam int MAP_BITS   = 65536;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = $clog2(MAP_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int BIDX_W     = WADDR_W + BIT_W;
   localparam int ZONE_W     = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index codes, taken from paddr[2]
   localparam logic CFG_FIRST_ZONE = 1'b0;
   localparam logic CFG_ZONE_COUNT = 1'b1;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_FULL   = 3'd1,
      ST_RANGE  = 3'd2,
      ST_DOUBLE = 3'd3,
      ST_BUSY   = 3'd4
   } status_type;

   typedef struct packed {
      logic              kind;
      logic [ZONE_W-1:0] block_number;
      logic              cache_busy;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ZONE_W-1:0] zone_number;
   } rsp_type;

endpackage

[rtl/zba_ram.sv]
// generic simple dual-port ram: one write port, one read port with
// registered read data. no dependencies.
module zba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/zone_bitmap_allocator.sv]
// zone_bitmap_allocator: first-fit used/free bitmap for disk zones.
// depends on zba_pkg and zba_ram.
//
// usage:
//  - request channel (req_valid, req_stall, req_data): kind 0 allocates the
//    lowest free zone, kind 1 frees block_number. one response per request.
//  - response channel (rsp_valid, rsp_stall, rsp_data): status and zone
//    number, held in an output register until the receiver drops stall.
//  - csr port (apb style): first_data_zone at 0x0, zone_count at 0x4.
//    write only while no request is in flight.
// operation:
//  - after reset the bitmap ram is swept once, one word a cycle
//    (MAP_WORDS = 2048 words), with bit 0 left set; req_stall stays high.
//  - a free reads its word (rd), then checks and clears its bit (chk); an
//    allocate runs rd and chk for each bitmap word it reads. a request answered
//    from the idle state (free out of range or busy, allocate with the map
//    known full) goes straight to done. a low-water word pointer skips words
//    known to be full, so a scan usually reads one word; after a free below
//    the pointer the scan restarts from that word. at worst it reads all words.
//  - one request at a time: req_stall is low only in the idle state. the
//    next request is taken while an earlier response still waits; if the
//    receiver stalls, the new response waits in the done state.
module zone_bitmap_allocator
   import zba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [4:0] {
      S_CLR  = 5'b00001,
      S_IDLE = 5'b00010,
      S_RD   = 5'b00100,
      S_CHK  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [ZONE_W-1:0]     first_ff, first_in;
   logic [ZONE_W-1:0]     count_ff, count_in;
   logic [WADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [WADDR_W:0]      hint_ff, hint_in;
   logic [WADDR_W-1:0]    addr_ff, addr_in;
   logic [BIT_W-1:0]      bitpos_ff, bitpos_in;
   logic                  kind_ff, kind_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  ram_we;
   logic [WADDR_W-1:0]    ram_waddr;
   logic [WORD_BITS-1:0]  ram_wdata;
   logic [WORD_BITS-1:0]  ram_rdata;

   logic                  csr_wr;
   logic [ZONE_W-1:0]     fdz;
   logic                  req_accept;
   logic                  out_load;
   logic [ZONE_W:0]       free_bit;
   logic [BIT_W-1:0]      low_zero;
   logic                  any_zero;
   logic [BIDX_W-1:0]     alloc_bit;
   logic [ZONE_W:0]       alloc_num;
   logic [WORD_BITS-1:0]  bit_mask;

   zba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // config port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == CFG_ZONE_COUNT) ?
                       {{(CSR_DATA_W-ZONE_W){1'b0}}, count_ff} :
                       {{(CSR_DATA_W-ZONE_W){1'b0}}, first_ff};

   always_comb begin
      first_in = first_ff;
      count_in = count_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            CFG_FIRST_ZONE: first_in = csr_pwdata[ZONE_W-1:0];
            CFG_ZONE_COUNT: count_in = csr_pwdata[ZONE_W-1:0];
            default: begin
               first_in = first_ff;
            end
         endcase
      end
   end

   // a first data zone of zero acts as one
   assign fdz = (first_ff == '0) ? ZONE_W'(1) : first_ff;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign out_load   = ~rsp_valid_ff | ~rsp_stall;

   assign free_bit = {1'b0, req_data.block_number} - {1'b0, fdz} + (ZONE_W+1)'(1);

   // lowest clear bit of the word just read
   always_comb begin
      low_zero = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!ram_rdata[i]) begin
            low_zero = BIT_W'(i);
         end
      end
   end

   assign any_zero  = ~&ram_rdata;
   assign alloc_bit = {addr_ff, low_zero};
   assign alloc_num = (ZONE_W+1)'(alloc_bit) + {1'b0, fdz} - (ZONE_W+1)'(1);
   assign bit_mask  = WORD_BITS'(1) << (kind_ff == KIND_ALLOC ? low_zero : bitpos_ff);

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      hint_in     = hint_ff;
      addr_in     = addr_ff;
      bitpos_in   = bitpos_ff;
      kind_in     = kind_ff;
      res_in      = res_ff;
      ram_we      = 1'b0;
      ram_waddr   = addr_ff;
      ram_wdata   = ram_rdata;

      case (state_ff)
         S_CLR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = (clr_addr_ff == '0) ? WORD_BITS'(1) : '0;
            clr_addr_in = clr_addr_ff + WADDR_W'(1);
            if (clr_addr_ff == WADDR_W'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               kind_in            = req_data.kind;
               res_in.zone_number = '0;
               res_in.status      = ST_OK;
               if (req_data.kind == KIND_ALLOC) begin
                  if (hint_ff == (WADDR_W+1)'(MAP_WORDS)) begin
                     res_in.status = ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     addr_in  = hint_ff[WADDR_W-1:0];
                     state_in = S_RD;
                  end
               end else begin
                  if (req_data.block_number < fdz || req_data.block_number >= count_ff) begin
                     res_in.status = ST_RANGE;
                     state_in      = S_DONE;
                  end else if (req_data.cache_busy) begin
                     res_in.status = ST_BUSY;
                     state_in      = S_DONE;
                  end else if (32'(free_bit) >= MAP_BITS) begin
                     res_in.status = ST_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     addr_in   = free_bit[BIDX_W-1:BIT_W];
                     bitpos_in = free_bit[BIT_W-1:0];
                     state_in  = S_RD;
                  end
               end
            end
         end

         S_RD: begin
            state_in = S_CHK;
         end

         S_CHK: begin
            if (kind_ff == KIND_ALLOC) begin
               if (!any_zero) begin
                  // word full: move the low-water pointer on
                  hint_in = hint_ff + (WADDR_W+1)'(1);
                  if (hint_ff == (WADDR_W+1)'(MAP_WORDS - 1)) begin
                     res_in.status = ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     addr_in  = addr_ff + WADDR_W'(1);
                     state_in = S_RD;
                  end
               end else if (32'(alloc_bit) >= MAP_BITS) begin
                  res_in.status = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata | bit_mask;
                  if (alloc_num >= {1'b0, count_ff}) begin
                     res_in.status = ST_RANGE;
                  end else begin
                     res_in.zone_number = alloc_num[ZONE_W-1:0];
                  end
                  state_in = S_DONE;
               end
            end else begin
               if ((ram_rdata & bit_mask) == '0) begin
                  res_in.status = ST_DOUBLE;
               end else begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata & ~bit_mask;
                  if ({1'b0, addr_ff} < hint_ff) begin
                     hint_in = {1'b0, addr_ff};
                  end
               end
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLR;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (state_ff == S_DONE && out_load) begin
         rsp_data_in  = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         first_ff     <= ZONE_W'(1);
         count_ff     <= '0;
         clr_addr_ff  <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         clr_addr_ff  <= clr_addr_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      bitpos_ff   <= bitpos_in;
      kind_ff     <= kind_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_clr_sweep_complete: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff == S_CLR) |-> $past(clr_addr_ff) == WADDR_W'(MAP_WORDS - 1))
      else $error("clearing pass ended early");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside done state");

   a_zone_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ST_OK |-> rsp_data_ff.zone_number == '0)
      else $error("nonzero zone number on failed request");

   a_hint_bound: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= (WADDR_W+1)'(MAP_WORDS))
      else $error("low-water pointer past end of map");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLR || state_ff == S_CHK))
      else $error("bitmap written outside clear or check state");
`endif

endmodule
